// ===== hdl/drsa_pkg.sv =====
// ----------------------------------------------------------------------------
// drsa_pkg: shared types and constants of the range split allocator
// Entry layout, operation and status codes, register indexes and limits.
// ----------------------------------------------------------------------------
package drsa_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int ALIGN_LOG2  = 16;
  localparam int ALIGN_BYTES = 1 << ALIGN_LOG2;

  localparam logic [62:0] M63        = '1;
  localparam logic [63:0] ALIGN_MASK = 64'(ALIGN_BYTES - 1);

  typedef enum logic [1:0] {
    ST_PENDING  = 2'd0,
    ST_ACTIVE   = 2'd1,
    ST_COMPLETE = 2'd2,
    ST_ERROR    = 2'd3
  } seg_state_t;

  typedef enum logic [2:0] {
    OP_START    = 3'd0,
    OP_REQUEST  = 3'd1,
    OP_PROGRESS = 3'd2,
    OP_COMPLETE = 3'd3,
    OP_ERROR    = 3'd4,
    OP_RELEASE  = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    STAT_OK         = 3'd0,
    STAT_CONN_LIMIT = 3'd1,
    STAT_NO_WORK    = 3'd2,
    STAT_UNKNOWN_ID = 3'd3,
    STAT_TABLE_FULL = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_FILE_SIZE = 2'd0,
    REG_MAX_CONN  = 2'd1,
    REG_MIN_SEG   = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_CHECK,
    S_APPLY,
    S_DONE
  } fsm_t;

  typedef enum logic [2:0] {
    MOD_NONE,
    MOD_START,
    MOD_ASSIGN,
    MOD_SPLIT,
    MOD_PROGRESS,
    MOD_COMPLETE,
    MOD_ERROR,
    MOD_RELEASE
  } mod_t;

  typedef struct packed {
    logic [15:0] id;
    logic [62:0] start;
    logic [62:0] last;
    logic [62:0] pos;
    logic [4:0]  owner;
    logic        owned;
    seg_state_t  st;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t ent;
  } slot_t;

  typedef struct packed {
    logic [62:0] file_size;
    logic [5:0]  max_conn;
    logic [40:0] min_seg;
  } cfg_t;

  function automatic logic [62:0] end_plus_one(input logic [62:0] last);
    end_plus_one = (last == M63) ? M63 : last + 63'd1;
  endfunction

endpackage

// ===== hdl/drsa_cell.sv =====
// ----------------------------------------------------------------------------
// drsa_cell: one slot of the entry ring
// Holds one table entry and takes its neighbor's entry when the ring moves.
// ----------------------------------------------------------------------------
module drsa_cell import drsa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t d,
  output slot_t q
);

  logic   valid;
  entry_t ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      ent <= d.ent;
    end
  end

  assign q = '{valid: valid, ent: ent};

endmodule

// ===== hdl/drsa_chain.sv =====
// ----------------------------------------------------------------------------
// drsa_chain: row of entry cells
// Each cell passes its entry toward the head; the tail takes a new word.
// ----------------------------------------------------------------------------
module drsa_chain import drsa_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  shift,
  input  slot_t tail,
  output slot_t head
);

  slot_t link [MAX_ENTRIES+1];

  assign link[MAX_ENTRIES] = tail;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    drsa_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .shift (shift),
      .d     (link[i+1]),
      .q     (link[i])
    );
  end

  assign head = link[0];

endmodule

// ===== hdl/drsa_regs.sv =====
// ----------------------------------------------------------------------------
// drsa_regs: configuration registers
// APB-style port with 64-bit data and registers at 8-byte spacing.
// ----------------------------------------------------------------------------
module drsa_regs import drsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  reg_idx_t idx;

  assign idx    = reg_idx_t'(paddr[4:3]);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.file_size <= '0;
      cfg.max_conn  <= 6'd8;
      cfg.min_seg   <= 41'd1048576;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_FILE_SIZE: cfg.file_size <= pwdata[62:0];
        REG_MAX_CONN:  cfg.max_conn  <= pwdata[5:0];
        REG_MIN_SEG:   cfg.min_seg   <= pwdata[40:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FILE_SIZE: prdata = {1'b0, cfg.file_size};
      REG_MAX_CONN:  prdata = {58'd0, cfg.max_conn};
      REG_MIN_SEG:   prdata = {23'd0, cfg.min_seg};
      default:       prdata = '0;
    endcase
  end

endmodule

// ===== hdl/dynamic_range_split_allocator.sv =====
// ----------------------------------------------------------------------------
// dynamic_range_split_allocator: ordered byte-range table with splitting
// Sixteen entries circulate in a ring of cells; a controller at the head
// scans, modifies, inserts and totals them one entry per cycle.
// ----------------------------------------------------------------------------
//   channel | signals                              | moves
//   input   | in_valid/in_ready, op .. byte_count  | one operation word
//   output  | out_valid/out_ready, status .. total | one result word
//   config  | psel/penable/pwrite/paddr/pwdata     | register write/read
//
// After a word is taken, its result passes through one lap of the ring to
// scan, the CALC and CHECK states to work out a split, one lap to apply the
// change and total, and the DONE state that loads the output register.
// The ring of cells is the only path to the table, so the laps set the word rate.
// Reset (synchronous) empties the table; configuration takes its reset values.
// A new word is taken once the previous one reached the output register; the
// result stays there until out_ready, and a finished word waits for that slot.
module dynamic_range_split_allocator import drsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  op,
  input  logic [4:0]  connection,
  input  logic [15:0] segment_id,
  input  logic [31:0] byte_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [15:0] assigned_id,
  output logic [62:0] assigned_start,
  output logic [62:0] assigned_end,
  output logic        parent_valid,
  output logic [15:0] parent_id,
  output logic [4:0]  active_count,
  output logic [4:0]  entry_count,
  output logic        all_complete,
  output logic [62:0] total_downloaded,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

  cfg_t  cfg;
  fsm_t  state, state_next;
  slot_t head, tail, wr, carry;
  logic  shift, last_step, carry_on;
  logic [IDX_W-1:0] cnt;

  // captured word
  op_t         op_q;
  logic [4:0]  conn_q;
  logic [15:0] seg_q;
  logic [31:0] bc_q;

  // scan results
  logic [CNT_W-1:0] act_cnt, entry_total;
  logic             pe_found, best_found, id_found;
  logic [IDX_W-1:0] pe_idx, best_idx, id_idx, tgt;
  logic [15:0]      pe_id, best_id, next_id, new_id;
  logic [62:0]      pe_pos, pe_last, best_pos, best_last;
  logic [63:0]      best_rem, h_rem;

  // split arithmetic
  logic [40:0] minsz;
  logic [63:0] split_a, pos_min, end_min, split_sel;
  logic        too_small;
  logic [62:0] split;

  // decision
  mod_t    kind, kind_next;
  status_t stat_next, res_stat;
  logic [15:0] res_id, res_pid;
  logic [62:0] res_start, res_end;
  logic        res_pv;

  // totals
  logic [CNT_W-1:0] s_act;
  logic             s_all;
  logic [62:0]      s_tot, t_d;
  logic [63:0]      t_sum;

  logic [63:0] np;
  logic [62:0] np_sat;
  entry_t      start_ent, split_ent;

  drsa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drsa_chain u_chain (
    .clk   (clk),
    .rst   (rst),
    .shift (shift),
    .tail  (tail),
    .head  (head)
  );

  assign in_ready  = (state == S_IDLE);
  assign shift     = (state == S_SCAN) || (state == S_APPLY);
  assign last_step = (cnt == IDX_W'(MAX_ENTRIES - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_SCAN;
      S_SCAN:  if (last_step) state_next = S_CALC;
      S_CALC:  state_next = S_CHECK;
      S_CHECK: state_next = S_APPLY;
      S_APPLY: if (last_step) state_next = S_DONE;
      S_DONE:  if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign h_rem = (head.ent.pos > head.ent.last) ? 64'd0 :
                 {1'b0, head.ent.last} - {1'b0, head.ent.pos} + 64'd1;

  assign minsz     = (cfg.min_seg == '0) ? 41'd1 : cfg.min_seg;
  assign split_sel = (split_a <= {1'b0, best_pos}) ? pos_min : split_a;

  // Request policy: owner limit, then reuse of idle entries, then a split.
  always_comb begin
    kind_next = MOD_NONE;
    stat_next = STAT_OK;
    unique case (op_q) inside
      OP_START: kind_next = MOD_START;
      OP_REQUEST: begin
        if (CMP_W'(act_cnt) >= CMP_W'(cfg.max_conn)) begin
          stat_next = STAT_CONN_LIMIT;
        end else if (pe_found) begin
          kind_next = MOD_ASSIGN;
        end else if (!best_found || cfg.file_size == '0 || too_small ||
                     split_sel > end_min) begin
          stat_next = STAT_NO_WORK;
        end else if (entry_total >= CNT_W'(MAX_ENTRIES)) begin
          stat_next = STAT_TABLE_FULL;
        end else begin
          kind_next = MOD_SPLIT;
        end
      end
      OP_PROGRESS, OP_COMPLETE, OP_ERROR, OP_RELEASE: begin
        if (!id_found) begin
          stat_next = STAT_UNKNOWN_ID;
        end else begin
          case (op_q)
            OP_PROGRESS: kind_next = MOD_PROGRESS;
            OP_COMPLETE: kind_next = MOD_COMPLETE;
            OP_ERROR:    kind_next = MOD_ERROR;
            default:     kind_next = MOD_RELEASE;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    start_ent = '{id: 16'd0, start: 63'd0,
                  last: (cfg.file_size == '0) ? M63 : cfg.file_size - 63'd1,
                  pos: 63'd0, owner: 5'd0, owned: 1'b0, st: ST_PENDING};
    split_ent = '{id: new_id, start: split, last: head.ent.last, pos: split,
                  owner: conn_q, owned: 1'b1, st: ST_ACTIVE};
    np     = {1'b0, head.ent.pos} + {32'd0, bc_q};
    np_sat = np[63] ? M63 : np[62:0];
    wr     = head;
    case (kind)
      MOD_START: begin
        wr.valid = (cnt == '0);
        wr.ent   = start_ent;
      end
      MOD_ASSIGN: if (cnt == tgt) begin
        wr.ent.st    = ST_ACTIVE;
        wr.ent.owner = conn_q;
        wr.ent.owned = 1'b1;
      end
      MOD_SPLIT: if (cnt == tgt) begin
        wr.ent.last = split - 63'd1;
      end
      MOD_PROGRESS: if (cnt == tgt) begin
        if (np_sat > head.ent.last) begin
          wr.ent.pos = end_plus_one(head.ent.last);
          wr.ent.st  = ST_COMPLETE;
        end else begin
          wr.ent.pos = np_sat;
        end
      end
      MOD_COMPLETE: if (cnt == tgt) begin
        wr.ent.pos = end_plus_one(head.ent.last);
        wr.ent.st  = ST_COMPLETE;
      end
      MOD_ERROR: if (cnt == tgt) begin
        wr.ent.st    = ST_ERROR;
        wr.ent.owner = 5'd0;
        wr.ent.owned = 1'b0;
      end
      MOD_RELEASE: if (cnt == tgt) begin
        if (head.ent.st != ST_COMPLETE) wr.ent.st = ST_PENDING;
        wr.ent.owner = 5'd0;
        wr.ent.owned = 1'b0;
      end
      default: ;
    endcase
  end

  // After an insert every later entry is held back one slot by the carry;
  // the free slot at the end of the table absorbs the last one.
  always_comb begin
    if (state == S_SCAN) begin
      tail = head;
    end else if (carry_on) begin
      tail = carry;
    end else begin
      tail = wr;
    end
  end

  assign t_d   = (tail.ent.pos > tail.ent.start) ? tail.ent.pos - tail.ent.start : 63'd0;
  assign t_sum = {1'b0, s_tot} + {1'b0, t_d};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      carry_on    <= 1'b0;
      out_valid   <= 1'b0;
      entry_total <= '0;
      next_id     <= '0;
    end else begin
      if (shift) cnt <= cnt + IDX_W'(1);
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) begin
          op_q       <= op_t'(op);
          conn_q     <= connection;
          seg_q      <= segment_id;
          bc_q       <= byte_count;
          cnt        <= '0;
          act_cnt    <= '0;
          pe_found   <= 1'b0;
          best_found <= 1'b0;
          best_rem   <= '0;
          id_found   <= 1'b0;
        end
        S_SCAN: if (head.valid) begin
          if (head.ent.st == ST_ACTIVE && head.ent.owned) act_cnt <= act_cnt + CNT_W'(1);
          if (!pe_found && (head.ent.st == ST_PENDING || head.ent.st == ST_ERROR)) begin
            pe_found <= 1'b1;
            pe_idx   <= cnt;
            pe_id    <= head.ent.id;
            pe_pos   <= head.ent.pos;
            pe_last  <= head.ent.last;
          end
          if (head.ent.st == ST_ACTIVE && h_rem > best_rem) begin
            best_found <= 1'b1;
            best_rem   <= h_rem;
            best_idx   <= cnt;
            best_id    <= head.ent.id;
            best_pos   <= head.ent.pos;
            best_last  <= head.ent.last;
          end
          if (!id_found && head.ent.id == seg_q) begin
            id_found <= 1'b1;
            id_idx   <= cnt;
          end
        end
        S_CALC: begin
          split_a   <= ({1'b0, best_pos} + {1'b0, best_rem[63:1]}) & ~ALIGN_MASK;
          pos_min   <= {1'b0, best_pos} + 64'(minsz);
          end_min   <= {1'b0, best_last} - 64'(minsz);
          too_small <= best_rem < 64'({minsz, 1'b0});
        end
        S_CHECK: begin
          kind      <= kind_next;
          res_stat  <= stat_next;
          split     <= split_sel[62:0];
          new_id    <= next_id;
          s_act     <= '0;
          s_all     <= 1'b1;
          s_tot     <= '0;
          carry_on  <= 1'b0;
          res_id    <= '0;
          res_start <= '0;
          res_end   <= '0;
          res_pv    <= 1'b0;
          res_pid   <= '0;
          tgt       <= '0;
          case (kind_next) inside
            MOD_START: begin
              entry_total <= CNT_W'(1);
              next_id     <= 16'd1;
            end
            MOD_ASSIGN: begin
              tgt       <= pe_idx;
              res_id    <= pe_id;
              res_start <= pe_pos;
              res_end   <= pe_last;
            end
            MOD_SPLIT: begin
              tgt         <= best_idx;
              entry_total <= entry_total + CNT_W'(1);
              next_id     <= next_id + 16'd1;
              res_id      <= next_id;
              res_start   <= split_sel[62:0];
              res_end     <= best_last;
              res_pv      <= 1'b1;
              res_pid     <= best_id;
            end
            MOD_PROGRESS, MOD_COMPLETE, MOD_ERROR, MOD_RELEASE: tgt <= id_idx;
            default: ;
          endcase
        end
        S_APPLY: begin
          if (kind == MOD_SPLIT && cnt == tgt) begin
            carry    <= '{valid: 1'b1, ent: split_ent};
            carry_on <= 1'b1;
          end else if (carry_on) begin
            carry <= wr;
          end
          if (last_step) carry_on <= 1'b0;
          if (tail.valid) begin
            if (tail.ent.st == ST_ACTIVE && tail.ent.owned) s_act <= s_act + CNT_W'(1);
            if (tail.ent.st != ST_COMPLETE) s_all <= 1'b0;
            s_tot <= t_sum[63] ? M63 : t_sum[62:0];
          end
        end
        S_DONE: if (!out_valid || out_ready) begin
          out_valid        <= 1'b1;
          status           <= res_stat;
          assigned_id      <= res_id;
          assigned_start   <= res_start;
          assigned_end     <= res_end;
          parent_valid     <= res_pv;
          parent_id        <= res_pid;
          active_count     <= 5'(s_act);
          entry_count      <= 5'(entry_total);
          all_complete     <= (entry_total != '0) && s_all;
          total_downloaded <= s_tot;
        end
        default: ;
      endcase
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    entry_total <= CNT_W'(MAX_ENTRIES))
    else $error("entry count exceeds table size");

  a_carry_apply: assert property (@(posedge clk) disable iff (rst)
    carry_on |-> state == S_APPLY)
    else $error("insert carry live outside the apply lap");

  a_result_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && (!out_valid || out_ready)) |=> out_valid && state == S_IDLE)
    else $error("finished word not presented");

  a_split_room: assert property (@(posedge clk) disable iff (rst)
    (state == S_APPLY && kind == MOD_SPLIT) |-> entry_total <= CNT_W'(MAX_ENTRIES))
    else $error("split applied to a full table");

endmodule

// ===== bench/dynamic_range_split_allocator_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_range_split_allocator_check: result predictor and comparator
// Watches the operation, result and register channels, keeps its own copy of
// the range table and compares every result word field by field in order.
// ----------------------------------------------------------------------------
module dynamic_range_split_allocator_check import drsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [2:0]  op,
  input  logic [4:0]  connection,
  input  logic [15:0] segment_id,
  input  logic [31:0] byte_count,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  status,
  input  logic [15:0] assigned_id,
  input  logic [62:0] assigned_start,
  input  logic [62:0] assigned_end,
  input  logic        parent_valid,
  input  logic [15:0] parent_id,
  input  logic [4:0]  active_count,
  input  logic [4:0]  entry_count,
  input  logic        all_complete,
  input  logic [62:0] total_downloaded,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          split_count
);

  localparam logic [63:0] TOP63 = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] aid;
    logic [62:0] astart;
    logic [62:0] aend;
    logic        pvalid;
    logic [15:0] pid;
    logic [4:0]  active;
    logic [4:0]  count;
    logic        allc;
    logic [62:0] total;
  } range_result_t;

  range_result_t expected_results[$];

  logic [15:0] tab_id    [MAX_ENTRIES];
  logic [63:0] tab_start [MAX_ENTRIES];
  logic [63:0] tab_end   [MAX_ENTRIES];
  logic [63:0] tab_pos   [MAX_ENTRIES];
  logic        tab_owned [MAX_ENTRIES];
  seg_state_t  tab_st    [MAX_ENTRIES];
  int          tab_used;
  logic [15:0] id_next;

  logic [63:0] size_cfg, conn_cfg, minseg_cfg;

  function automatic int owned_active();
    int n;
    n = 0;
    for (int i = 0; i < tab_used; i++)
      if (tab_st[i] == ST_ACTIVE && tab_owned[i]) n++;
    return n;
  endfunction

  task automatic create_entry(input int i, input logic [63:0] lo, input logic [63:0] hi);
    tab_id[i] = id_next;
    id_next = id_next + 16'd1;
    tab_start[i] = lo;
    tab_end[i] = hi;
    tab_pos[i] = lo;
    tab_owned[i] = 1'b0;
    tab_st[i] = ST_PENDING;
  endtask

  task automatic hand_out(input int i, inout range_result_t r);
    tab_st[i] = ST_ACTIVE;
    tab_owned[i] = 1'b1;
    r.aid = tab_id[i];
    r.astart = tab_pos[i][62:0];
    r.aend = tab_end[i][62:0];
  endtask

  task automatic grant_range(inout range_result_t r);
    int best;
    logic [63:0] best_rem, rem, minsz, cut;
    best = -1;
    best_rem = 0;
    if (64'(owned_active()) >= conn_cfg) begin
      r.status = STAT_CONN_LIMIT;
      return;
    end
    for (int i = 0; i < tab_used; i++) begin
      if (tab_st[i] == ST_PENDING || tab_st[i] == ST_ERROR) begin
        hand_out(i, r);
        return;
      end
    end
    for (int i = 0; i < tab_used; i++) begin
      if (tab_st[i] == ST_ACTIVE) begin
        rem = (tab_pos[i] > tab_end[i]) ? 64'd0 : tab_end[i] - tab_pos[i] + 64'd1;
        if (rem > best_rem) begin
          best_rem = rem;
          best = i;
        end
      end
    end
    minsz = (minseg_cfg == 0) ? 64'd1 : minseg_cfg;
    if (best < 0 || size_cfg == 0 || best_rem < minsz * 2) begin
      r.status = STAT_NO_WORK;
      return;
    end
    cut = tab_pos[best] + best_rem / 2;
    cut = (cut / ALIGN_BYTES) * ALIGN_BYTES;
    if (cut <= tab_pos[best]) cut = tab_pos[best] + minsz;
    // The subtraction wraps like the unsigned arithmetic it mirrors.
    if (cut > tab_end[best] - minsz) begin
      r.status = STAT_NO_WORK;
      return;
    end
    if (tab_used >= MAX_ENTRIES) begin
      r.status = STAT_TABLE_FULL;
      return;
    end
    for (int j = tab_used; j > best + 1; j--) begin
      tab_id[j] = tab_id[j-1];
      tab_start[j] = tab_start[j-1];
      tab_end[j] = tab_end[j-1];
      tab_pos[j] = tab_pos[j-1];
      tab_owned[j] = tab_owned[j-1];
      tab_st[j] = tab_st[j-1];
    end
    tab_used++;
    create_entry(best + 1, cut, tab_end[best]);
    tab_end[best] = cut - 64'd1;
    hand_out(best + 1, r);
    r.pvalid = 1'b1;
    r.pid = tab_id[best];
    split_count++;
  endtask

  task automatic predict_word(input logic [2:0] code, input logic [15:0] sid,
                              input logic [31:0] bytes);
    range_result_t r;
    int k;
    logic [63:0] np, sum, d;
    logic all;
    r = '{default: '0};
    k = -1;
    case (code) inside
      OP_START: begin
        tab_used = 0;
        id_next = 0;
        create_entry(0, 64'd0, (size_cfg == 0) ? TOP63 : size_cfg - 64'd1);
        tab_used = 1;
      end
      OP_REQUEST: grant_range(r);
      OP_PROGRESS, OP_COMPLETE, OP_ERROR, OP_RELEASE: begin
        for (int i = tab_used - 1; i >= 0; i--)
          if (tab_id[i] == sid) k = i;
        if (k < 0) begin
          r.status = STAT_UNKNOWN_ID;
        end else if (code == OP_PROGRESS) begin
          np = tab_pos[k] + 64'(bytes);
          if (np > TOP63) np = TOP63;
          tab_pos[k] = np;
          if (np > tab_end[k]) begin
            tab_pos[k] = (tab_end[k] >= TOP63) ? TOP63 : tab_end[k] + 64'd1;
            tab_st[k] = ST_COMPLETE;
          end
        end else if (code == OP_COMPLETE) begin
          tab_st[k] = ST_COMPLETE;
          tab_pos[k] = (tab_end[k] >= TOP63) ? TOP63 : tab_end[k] + 64'd1;
        end else begin
          if (code == OP_ERROR) tab_st[k] = ST_ERROR;
          else if (tab_st[k] != ST_COMPLETE) tab_st[k] = ST_PENDING;
          tab_owned[k] = 1'b0;
        end
      end
      default: ;
    endcase
    all = 1'b1;
    sum = 0;
    for (int i = 0; i < tab_used; i++) begin
      if (tab_st[i] != ST_COMPLETE) all = 1'b0;
      d = (tab_pos[i] > tab_start[i]) ? tab_pos[i] - tab_start[i] : 64'd0;
      sum = sum + d;
      if (sum > TOP63) sum = TOP63;
    end
    r.active = 5'(owned_active());
    r.count = 5'(tab_used);
    r.allc = (tab_used > 0) && all;
    r.total = sum[62:0];
    expected_results.insert(expected_results.size(), r);
  endtask

  function automatic int field_bad(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    range_result_t e;
    int bad;
    if (rst) begin
      expected_results.delete();
      tab_used = 0;
      id_next = 0;
      size_cfg = 0;
      conn_cfg = 8;
      minseg_cfg = 64'd1048576;
      fail_count = 0;
      pending = 0;
      split_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:3])
          REG_FILE_SIZE: size_cfg = {1'b0, pwdata[62:0]};
          REG_MAX_CONN:  conn_cfg = 64'(pwdata[5:0]);
          REG_MIN_SEG:   minseg_cfg = 64'(pwdata[40:0]);
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_word(op, segment_id, byte_count);
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no operation waiting for it");
          fail_count++;
        end else begin
          e = expected_results.pop_front();
          bad = field_bad("status", 64'(e.status), 64'(status))
              + field_bad("assigned_id", 64'(e.aid), 64'(assigned_id))
              + field_bad("assigned_start", 64'(e.astart), 64'(assigned_start))
              + field_bad("assigned_end", 64'(e.aend), 64'(assigned_end))
              + field_bad("parent_valid", 64'(e.pvalid), 64'(parent_valid))
              + field_bad("parent_id", 64'(e.pid), 64'(parent_id))
              + field_bad("active_count", 64'(e.active), 64'(active_count))
              + field_bad("entry_count", 64'(e.count), 64'(entry_count))
              + field_bad("all_complete", 64'(e.allc), 64'(all_complete))
              + field_bad("total_downloaded", 64'(e.total), 64'(total_downloaded));
          if (bad != 0) fail_count++;
        end
      end
      pending = expected_results.size();
    end
  end

endmodule

// ===== bench/dynamic_range_split_allocator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dynamic_range_split_allocator_test: top level of the allocator bench
// Drives directed and random operation words over several register settings,
// with random idling on both channels, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module dynamic_range_split_allocator_test;
  import drsa_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int         STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = OP_START;
  logic [4:0]  connection = '0;
  logic [15:0] segment_id = '0;
  logic [31:0] byte_count = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] assigned_id, parent_id;
  logic [62:0] assigned_start, assigned_end, total_downloaded;
  logic        parent_valid, all_complete;
  logic [4:0]  active_count, entry_count;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int  fail_count, pending, split_count;
  int  words_sent = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;
  int  ready_left = 0;

  always #6 clk = ~clk;

  dynamic_range_split_allocator i_dut (.*);

  dynamic_range_split_allocator_check i_check (.*);

  // Receiver stalls in bursts; a quiet run keeps it ready throughout.
  always @(posedge clk) begin
    if (quiet) begin
      out_ready <= 1'b1;
    end else if (ready_left > 0) begin
      ready_left <= ready_left - 1;
    end else begin
      out_ready <= 1'($urandom_range(1));
      ready_left <= int'($urandom_range(14, 1));
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("dynamic_range_split_allocator_test failed");
      $finish;
    end
  end

  task automatic reg_write(input reg_idx_t idx, input logic [63:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 3'b000};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic send_word(input logic [2:0] code, input logic [4:0] conn,
                           input logic [15:0] sid, input logic [31:0] bytes);
    if (!quiet && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk);
    end
    op <= code;
    connection <= conn;
    segment_id <= sid;
    byte_count <= bytes;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  task automatic random_word();
    int pick, idsel;
    logic [2:0]  code;
    logic [15:0] sid;
    logic [31:0] bytes;
    pick = $urandom_range(99);
    if (pick < 3)       code = OP_START;
    else if (pick < 40) code = OP_REQUEST;
    else if (pick < 64) code = OP_PROGRESS;
    else if (pick < 76) code = OP_COMPLETE;
    else if (pick < 84) code = OP_ERROR;
    else if (pick < 97) code = OP_RELEASE;
    else if (pick < 98) code = OP_SPARE_LO;
    else                code = OP_SPARE_HI;
    idsel = $urandom_range(19);
    if (idsel < 16)      sid = 16'($urandom_range(24));
    else if (idsel < 18) sid = 16'($urandom);
    else                 sid = 16'hFFFF;
    case ($urandom_range(3))
      0: bytes = $urandom_range(1 << 20);
      1: bytes = $urandom;
      2: bytes = 32'hFFFF_FFFF;
      default: bytes = $urandom_range(1 << 16);
    endcase
    send_word(code, 5'($urandom), sid, bytes);
  endtask

  task automatic run_phase(input logic [63:0] size, input logic [63:0] conns,
                           input logic [63:0] minseg, input int count, input bit pause);
    drain();
    reg_write(REG_FILE_SIZE, size);
    reg_write(REG_MAX_CONN, conns);
    reg_write(REG_MIN_SEG, minseg);
    send_word(OP_START, 5'd0, 16'd0, 32'd0);
    for (int n = 0; n < count; n++) begin
      // Hold the sender off once until the allocator has fully drained.
      if (pause && n == count / 2) drain();
      random_word();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset settings: unknown size, empty table first.
    send_word(OP_REQUEST, 5'd0, 16'd0, 32'd0);
    send_word(OP_PROGRESS, 5'd1, 16'd0, 32'd5);
    send_word(OP_START, 5'd0, 16'd0, 32'd0);
    send_word(OP_REQUEST, 5'd31, 16'd0, 32'd0);
    send_word(OP_REQUEST, 5'd2, 16'd0, 32'd0);
    send_word(OP_PROGRESS, 5'd0, 16'd0, 32'hFFFF_FFFF);
    send_word(OP_ERROR, 5'd0, 16'd0, 32'd0);
    send_word(OP_REQUEST, 5'd7, 16'd0, 32'd0);
    send_word(OP_RELEASE, 5'd0, 16'd0, 32'd0);
    send_word(OP_COMPLETE, 5'd0, 16'd0, 32'd0);
    send_word(OP_RELEASE, 5'd0, 16'd0, 32'd0);
    send_word(OP_COMPLETE, 5'd0, 16'hFFFF, 32'd0);
    send_word(OP_SPARE_LO, 5'd31, 16'hFFFF, 32'hFFFF_FFFF);
    send_word(OP_SPARE_HI, 5'd0, 16'd0, 32'd0);

    // Small range with aligned splits, then a run of requests filling the table.
    drain();
    reg_write(REG_FILE_SIZE, 64'd1 << 32);
    reg_write(REG_MAX_CONN, 64'd32);
    reg_write(REG_MIN_SEG, 64'd1);
    send_word(OP_START, 5'd0, 16'd0, 32'd0);
    for (int n = 0; n < 18; n++) send_word(OP_REQUEST, 5'(n), 16'd0, 32'd0);
    send_word(OP_COMPLETE, 5'd0, 16'd3, 32'd0);
    send_word(OP_RELEASE, 5'd0, 16'd4, 32'd0);

    run_phase(64'd1 << 32, 64'd8, 64'd1 << 20, 300, 1'b1);
    run_phase(64'h7FFF_FFFF_FFFF_FFFF, 64'd32, 64'd1, 300, 1'b0);
    run_phase(64'd3145728 + 64'd12345, 64'd1, 64'd0, 250, 1'b0);
    run_phase(64'd1 << 40, 64'd63, 64'h1FF_FFFF_FFFF, 250, 1'b0);
    run_phase(64'd1, 64'd16, 64'd65536, 150, 1'b0);
    run_phase(64'd200000, 64'd4, 64'd65536, 250, 1'b0);
    drain();
    quiet = 1'b1;
    run_phase(64'd1 << 36, 64'd32, 64'd65536, 300, 1'b0);

    drain();
    repeat (60) @(posedge clk);
    $display("Covered %0d operation words over nine register settings, %0d splits.",
             words_sent, split_count);
    if (fail_count == 0)
      $display("dynamic_range_split_allocator_test passed");
    else
      $display("dynamic_range_split_allocator_test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/drsa_pkg.sv
hdl/drsa_cell.sv
hdl/drsa_chain.sv
hdl/drsa_regs.sv
hdl/dynamic_range_split_allocator.sv
bench/dynamic_range_split_allocator_check.sv
bench/dynamic_range_split_allocator_test.sv
